/* hdl/pfsd_pkg.sv */
// Shared types and constants for the paged frame buffer shape drawer.
package pfsd_pkg;

   localparam int DEF_SCREEN_WIDTH  = 128;
   localparam int DEF_SCREEN_HEIGHT = 128;

   typedef enum logic [2:0] {
      KIND_PIXEL = 3'd0,
      KIND_LINE  = 3'd1,
      KIND_RECT  = 3'd2,
      KIND_CIRC  = 3'd3,
      KIND_READ  = 3'd4,
      KIND_CLEAR = 3'd5,
      KIND_NOP6  = 3'd6,
      KIND_NOP7  = 3'd7
   } kind_type;

   typedef struct packed {
      logic load;
      logic clr_init;
      logic clr_write;
      logic rd_point;
      logic wr_point;
      logic rd_index;
      logic step;
      logic flag_err;
      logic latch_data;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     zero_rect;
      logic     read_oob;
      logic     pt_en;
      logic     pt_on;
      logic     pt_last;
      logic     clr_last;
   } status_type;

endpackage

/* hdl/pfsd_chan_if.sv */
// Request and response channel interfaces of the shape drawer.
interface pfsd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] x_a;
   logic [7:0] y_a;
   logic [7:0] x_b;
   logic [7:0] y_b;
   logic [7:0] rect_width;
   logic [7:0] rect_height;
   logic [7:0] radius;
   logic       color;
   logic [10:0] read_index;

   modport source (output valid, kind, x_a, y_a, x_b, y_b, rect_width, rect_height,
                   radius, color, read_index, input ready);
   modport sink (input valid, kind, x_a, y_a, x_b, y_b, rect_width, rect_height,
                 radius, color, read_index, output ready);
endinterface

interface pfsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       error;

   modport source (output valid, read_data, error, input ready);
   modport sink (input valid, read_data, error, output ready);
endinterface

/* hdl/paged_framebuffer_shape_drawer.sv */
// Top level of the paged frame buffer shape drawer.
//
//   channel   direction  contents
//   req_chan  in         kind, coordinates, sizes, radius, color, read_index
//   rsp_chan  out        read_data, error (one item per request)
//
// A pixel is a read, then a write of its byte, on the single frame store port; a
// skipped outline interior point or off-screen pixel is stepped past with no
// store access.
// After reset, and for a clear command, a clearing pass writes one byte a cycle:
// SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes, 2048 by default; no item is taken then.
// A result waits in its output register while the next item is accepted.
module paged_framebuffer_shape_drawer
   import pfsd_pkg::*;
#(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input logic       clock,
   input logic       reset,
   pfsd_req_if.sink  req_chan,
   pfsd_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;

   pfsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pfsd_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .in_kind        (req_chan.kind),
      .in_x_a         (req_chan.x_a),
      .in_y_a         (req_chan.y_a),
      .in_x_b         (req_chan.x_b),
      .in_y_b         (req_chan.y_b),
      .in_rect_width  (req_chan.rect_width),
      .in_rect_height (req_chan.rect_height),
      .in_radius      (req_chan.radius),
      .in_color       (req_chan.color),
      .in_read_index  (req_chan.read_index),
      .out_read_data  (rsp_chan.read_data),
      .out_error      (rsp_chan.error)
   );

endmodule

/* hdl/pfsd_ctrl.sv */
// Command sequencer of the shape drawer.
module pfsd_ctrl
   import pfsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_CLEAR    = 7'b0000001,
      S_IDLE     = 7'b0000010,
      S_DISPATCH = 7'b0000100,
      S_POINT    = 7'b0001000,
      S_WRITE    = 7'b0010000,
      S_RDWAIT   = 7'b0100000,
      S_RESP     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      clear_rsp_ff, clear_rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      clear_rsp_in = clear_rsp_ff;
      cmd          = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = clear_rsp_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (status.kind) inside
               KIND_PIXEL, KIND_LINE, KIND_CIRC: state_in = S_POINT;
               KIND_RECT: begin
                  if (status.zero_rect) begin
                     cmd.flag_err = 1'b1;
                     state_in     = S_RESP;
                  end else begin
                     state_in = S_POINT;
                  end
               end
               KIND_READ: begin
                  if (status.read_oob) begin
                     cmd.flag_err = 1'b1;
                     state_in     = S_RESP;
                  end else begin
                     cmd.rd_index = 1'b1;
                     state_in     = S_RDWAIT;
                  end
               end
               KIND_CLEAR: begin
                  cmd.clr_init = 1'b1;
                  clear_rsp_in = 1'b1;
                  state_in     = S_CLEAR;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_POINT: begin
            if (status.pt_en && status.pt_on) begin
               cmd.rd_point = 1'b1;
               state_in     = S_WRITE;
            end else begin
               // Skipped interior of an outline, or a pixel off the screen.
               cmd.flag_err = status.pt_en;
               if (status.pt_last) begin
                  state_in = S_RESP;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         S_WRITE: begin
            cmd.wr_point = 1'b1;
            if (status.pt_last) begin
               state_in = S_RESP;
            end else begin
               cmd.step = 1'b1;
               state_in = S_POINT;
            end
         end
         S_RDWAIT: begin
            cmd.latch_data = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               clear_rsp_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_rsp_ff <= clear_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_point |-> $past(cmd.rd_point))
      else $error("point write without a preceding read");
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DISPATCH)
      else $error("accepted item not dispatched");
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrites an untaken result");

endmodule

/* hdl/pfsd_datapath.sv */
// Shape point generators, frame store and result registers of the shape drawer.
module pfsd_datapath
   import pfsd_pkg::*;
#(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [2:0]  in_kind,
   input  logic [7:0]  in_x_a,
   input  logic [7:0]  in_y_a,
   input  logic [7:0]  in_x_b,
   input  logic [7:0]  in_y_b,
   input  logic [7:0]  in_rect_width,
   input  logic [7:0]  in_rect_height,
   input  logic [7:0]  in_radius,
   input  logic        in_color,
   input  logic [10:0] in_read_index,
   output logic [7:0]  out_read_data,
   output logic        out_error
);

   localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);

   logic [7:0] mem [STORE_BYTES];
   logic [7:0] rdata_ff;

   kind_type    kind_ff;
   logic [7:0]  xa_ff, ya_ff, xb_ff, yb_ff;
   logic        color_ff;
   logic [10:0] ridx_ff;
   logic        zero_rect_ff;

   // Line state.
   logic signed [11:0] ldx_ff, ldy_ff, lacc_ff, lacc_in;
   logic               up_x_ff, up_y_ff;
   logic [7:0]         lx_ff, ly_ff, lx_in, ly_in;
   logic signed [12:0] twice;

   // Rectangle state.
   logic [8:0] rx_ff, ry_ff, rx_in, ry_in, right_ff, bottom_ff;

   // Circle state.
   logic signed [9:0]  ca_ff, cb_ff, ca_in, cb_in, ca_nx, cb_nx;
   logic signed [15:0] cacc_ff, cacc_in, cacc_nx;
   logic [2:0]         oct_ff, oct_in;
   logic [7:0]         ua, ub;

   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] waddr_ff;
   logic [2:0]        wbit_ff;
   logic              err_ff, err_in;
   logic [7:0]        data_ff, data_in;
   logic [7:0]        rsp_data_ff;
   logic              rsp_err_ff;

   logic [7:0]        pt_x, pt_y;
   logic              pt_en, pt_last;
   logic [ADDR_W-1:0] pt_addr;
   logic [7:0]        mask, wdata;
   logic              plot_set;

   logic [7:0] dx8, dy8;
   assign dx8 = (in_x_b > in_x_a) ? in_x_b - in_x_a : in_x_a - in_x_b;
   assign dy8 = (in_y_b > in_y_a) ? in_y_b - in_y_a : in_y_a - in_y_b;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff      <= kind_type'(in_kind);
         xa_ff        <= in_x_a;
         ya_ff        <= in_y_a;
         xb_ff        <= in_x_b;
         yb_ff        <= in_y_b;
         color_ff     <= in_color;
         ridx_ff      <= in_read_index;
         zero_rect_ff <= (in_rect_width == 8'd0) || (in_rect_height == 8'd0);
         ldx_ff       <= 12'(dx8);
         ldy_ff       <= -$signed(12'(dy8));
         up_x_ff      <= in_x_a < in_x_b;
         up_y_ff      <= in_y_a < in_y_b;
         right_ff     <= 9'(in_x_a) + 9'(in_rect_width) - 9'd1;
         bottom_ff    <= 9'(in_y_a) + 9'(in_rect_height) - 9'd1;
      end
   end

   // Bresenham step.
   assign twice = {lacc_ff, 1'b0};
   always_comb begin
      lacc_in = lacc_ff;
      lx_in   = lx_ff;
      ly_in   = ly_ff;
      if (cmd.load) begin
         lacc_in = $signed(12'(dx8)) - $signed(12'(dy8));
         lx_in   = in_x_a;
         ly_in   = in_y_a;
      end else if (cmd.step) begin
         if (twice >= 13'(ldy_ff)) begin
            lacc_in = lacc_in + ldy_ff;
            lx_in   = up_x_ff ? lx_ff + 8'd1 : lx_ff - 8'd1;
         end
         if (twice <= 13'(ldx_ff)) begin
            lacc_in = lacc_in + ldx_ff;
            ly_in   = up_y_ff ? ly_ff + 8'd1 : ly_ff - 8'd1;
         end
      end
   end

   // Rectangle scan, column by column.
   always_comb begin
      rx_in = rx_ff;
      ry_in = ry_ff;
      if (cmd.load) begin
         rx_in = 9'(in_x_a);
         ry_in = 9'(in_y_a);
      end else if (cmd.step) begin
         if (ry_ff == bottom_ff) begin
            ry_in = 9'(ya_ff);
            rx_in = rx_ff + 9'd1;
         end else begin
            ry_in = ry_ff + 9'd1;
         end
      end
   end

   // Midpoint circle: eight octant points per step of the decision variable.
   always_comb begin
      cb_nx = cb_ff + 10'sd1;
      if (cacc_ff < 0) begin
         ca_nx   = ca_ff;
         cacc_nx = cacc_ff + 16'(cb_nx <<< 1) + 16'sd1;
      end else begin
         ca_nx   = ca_ff - 10'sd1;
         cacc_nx = cacc_ff + 16'((cb_nx - ca_nx) <<< 1) + 16'sd1;
      end
      ca_in   = ca_ff;
      cb_in   = cb_ff;
      cacc_in = cacc_ff;
      oct_in  = oct_ff;
      if (cmd.load) begin
         ca_in   = 10'(in_radius);
         cb_in   = '0;
         cacc_in = 16'sd1 - 16'(in_radius);
         oct_in  = '0;
      end else if (cmd.step) begin
         oct_in = oct_ff + 3'd1;
         if (oct_ff == 3'd7) begin
            ca_in   = ca_nx;
            cb_in   = cb_nx;
            cacc_in = cacc_nx;
         end
      end
   end

   assign ua = ca_ff[7:0];
   assign ub = cb_ff[7:0];

   always_comb begin
      pt_x    = xa_ff;
      pt_y    = ya_ff;
      pt_en   = 1'b1;
      pt_last = 1'b1;
      plot_set = color_ff;
      case (kind_ff)
         KIND_LINE: begin
            pt_x    = lx_ff;
            pt_y    = ly_ff;
            pt_last = (lx_ff == xb_ff) && (ly_ff == yb_ff);
         end
         KIND_RECT: begin
            pt_x     = rx_ff[7:0];
            pt_y     = ry_ff[7:0];
            plot_set = 1'b1;
            pt_en    = color_ff || rx_ff == 9'(xa_ff) || rx_ff == right_ff ||
                       ry_ff == 9'(ya_ff) || ry_ff == bottom_ff;
            pt_last  = (rx_ff == right_ff) && (ry_ff == bottom_ff);
         end
         KIND_CIRC: begin
            case (oct_ff)
               3'd0: begin pt_x = xa_ff + ua; pt_y = ya_ff + ub; end
               3'd1: begin pt_x = xa_ff + ub; pt_y = ya_ff + ua; end
               3'd2: begin pt_x = xa_ff - ub; pt_y = ya_ff + ua; end
               3'd3: begin pt_x = xa_ff - ua; pt_y = ya_ff + ub; end
               3'd4: begin pt_x = xa_ff - ua; pt_y = ya_ff - ub; end
               3'd5: begin pt_x = xa_ff - ub; pt_y = ya_ff - ua; end
               3'd6: begin pt_x = xa_ff + ub; pt_y = ya_ff - ua; end
               default: begin pt_x = xa_ff + ua; pt_y = ya_ff - ub; end
            endcase
            pt_last = (oct_ff == 3'd7) && (ca_nx < cb_nx);
         end
         default: ;
      endcase
   end

   assign pt_addr = ADDR_W'(14'(pt_y[7:3]) * 14'(SCREEN_WIDTH) + 14'(pt_x));
   assign mask    = 8'd1 << wbit_ff;
   assign wdata   = plot_set ? (rdata_ff | mask) : (rdata_ff & ~mask);

   assign clr_in = cmd.clr_init ? '0 : (cmd.clr_write ? clr_ff + ADDR_W'(1) : clr_ff);

   always_comb begin
      err_in  = err_ff;
      data_in = data_ff;
      if (cmd.load) begin
         err_in  = 1'b0;
         data_in = '0;
      end else begin
         if (cmd.flag_err) begin
            err_in = 1'b1;
         end
         if (cmd.latch_data) begin
            data_in = rdata_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_write) begin
         mem[clr_ff] <= '0;
      end else if (cmd.wr_point) begin
         mem[waddr_ff] <= wdata;
      end
      if (cmd.rd_point) begin
         rdata_ff <= mem[pt_addr];
      end else if (cmd.rd_index) begin
         rdata_ff <= mem[ADDR_W'(ridx_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_point) begin
         waddr_ff <= pt_addr;
         wbit_ff  <= pt_y[2:0];
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= data_ff;
         rsp_err_ff  <= err_ff;
      end
      lacc_ff <= lacc_in;
      lx_ff   <= lx_in;
      ly_ff   <= ly_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      ca_ff   <= ca_in;
      cb_ff   <= cb_in;
      cacc_ff <= cacc_in;
      oct_ff  <= oct_in;
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         err_ff <= err_in;
      end
   end

   assign status.kind      = kind_ff;
   assign status.zero_rect = zero_rect_ff;
   assign status.read_oob  = 14'(ridx_ff) >= 14'(STORE_BYTES);
   assign status.pt_en     = pt_en;
   assign status.pt_on     = (9'(pt_x) < 9'(SCREEN_WIDTH)) && (9'(pt_y) < 9'(SCREEN_HEIGHT));
   assign status.pt_last   = pt_last;
   assign status.clr_last  = clr_ff == ADDR_W'(STORE_BYTES - 1);

   assign out_read_data = rsp_data_ff;
   assign out_error     = rsp_err_ff;

endmodule
